### sv/mf15_pkg.sv
// Package: shared types and constants for the 15-bit minifloat unit.
`timescale 1ns / 1ps
package mf15_pkg;
	localparam logic [14:0] POS_INF  = 15'd15360;
	localparam logic [14:0] NEG_INF  = 15'd31744;
	localparam logic [14:0] NAN_VAL  = 15'd15361;
	localparam logic [14:0] NEG_ZERO = 15'd16384;
	localparam int          BIAS     = 7;
	localparam logic        OP_ADD   = 1'b0;
	localparam logic        OP_MUL   = 1'b1;

	// Unnormalized value: n * 2^(k) with k held as a signed exponent.
	typedef struct packed {
		logic               special;  // result fixed by special-case rules
		logic [14:0]        spec_val;
		logic               sign;
		logic [24:0]        n;
		logic signed [7:0]  k;
	} mf15_raw_t;
endpackage

### sv/mf15_front.sv
// Front stage: operand unpacking, special cases, aligned add or raw multiply.
`timescale 1ns / 1ps
module mf15_front (
	input  logic                 action,
	input  logic [14:0]          operand_a,
	input  logic [14:0]          operand_b,
	output mf15_pkg::mf15_raw_t  raw
);
	logic        sa, sb;
	logic [3:0]  ea, eb;
	logic [9:0]  fa, fb;
	logic [10:0] ga, gb;
	logic [3:0]  xa, xb, emin;
	logic        nan_a, nan_b, inf_a, inf_b, zer_a, zer_b;
	logic [24:0] x, y;
	logic [21:0] prod;

	always_comb begin
		sa = operand_a[14]; ea = operand_a[13:10]; fa = operand_a[9:0];
		sb = operand_b[14]; eb = operand_b[13:10]; fb = operand_b[9:0];
		ga = {(ea != 4'd0), fa};
		gb = {(eb != 4'd0), fb};
		xa = (ea == 4'd0) ? 4'd1 : ea;
		xb = (eb == 4'd0) ? 4'd1 : eb;
		nan_a = (ea == 4'd15) && (fa != 10'd0);
		nan_b = (eb == 4'd15) && (fb != 10'd0);
		inf_a = (ea == 4'd15) && (fa == 10'd0);
		inf_b = (eb == 4'd15) && (fb == 10'd0);
		zer_a = (ea == 4'd0) && (fa == 10'd0);
		zer_b = (eb == 4'd0) && (fb == 10'd0);
		emin = (xa < xb) ? xa : xb;
		// finite exponent gap is at most 13: aligned significand needs 24 bits, sum 25
		x = 25'd0; y = 25'd0;
		prod = 22'(ga) * 22'(gb);
		raw = '0;
		if (action == mf15_pkg::OP_MUL) begin
			raw.sign = sa ^ sb;
			if (nan_a || nan_b) begin
				raw.special = 1'b1; raw.spec_val = mf15_pkg::NAN_VAL;
			end else if (inf_a || inf_b) begin
				raw.special = 1'b1;
				raw.spec_val = (zer_a || zer_b) ? mf15_pkg::NAN_VAL :
					((sa ^ sb) ? mf15_pkg::NEG_INF : mf15_pkg::POS_INF);
			end
			raw.n = 25'(prod);
			raw.k = 8'(signed'({4'd0, xa}) + signed'({4'd0, xb}) - 8'sd34);
		end else begin
			if (nan_a || nan_b) begin
				raw.special = 1'b1; raw.spec_val = mf15_pkg::NAN_VAL;
			end else if (inf_a && inf_b) begin
				raw.special = 1'b1;
				raw.spec_val = (sa != sb) ? mf15_pkg::NAN_VAL :
					(sa ? mf15_pkg::NEG_INF : mf15_pkg::POS_INF);
			end else if (inf_a) begin
				raw.special = 1'b1; raw.spec_val = sa ? mf15_pkg::NEG_INF : mf15_pkg::POS_INF;
			end else if (inf_b) begin
				raw.special = 1'b1; raw.spec_val = sb ? mf15_pkg::NEG_INF : mf15_pkg::POS_INF;
			end else if (zer_a && zer_b) begin
				raw.special = 1'b1; raw.spec_val = (sa && sb) ? mf15_pkg::NEG_ZERO : 15'd0;
			end
			x = 25'(ga) << (xa - emin);
			y = 25'(gb) << (xb - emin);
			if (sa == sb) begin
				raw.sign = sa; raw.n = x + y;
			end else if (x > y) begin
				raw.sign = sa; raw.n = x - y;
			end else begin
				raw.sign = sb; raw.n = y - x;
				if (y == x) raw.sign = 1'b0;
			end
			raw.k = 8'(signed'({4'd0, emin}) - 8'sd17);
		end
	end
endmodule

### sv/mf15_pack.sv
// Pack stage: leading-one search and rounding-free packing to 15 bits.
`timescale 1ns / 1ps
module mf15_pack (
	input  mf15_pkg::mf15_raw_t raw,
	output logic [14:0]         res
);
	logic [4:0]         msb;
	logic               nz;
	logic signed [8:0]  bexp;
	logic signed [8:0]  sh;
	logic [24:0]        mant;
	logic [14:0]        s;

	always_comb begin
		msb = 5'd0; nz = 1'b0;
		for (int i = 0; i < 25; i++) begin
			if (raw.n[i]) begin
				msb = 5'(i); nz = 1'b1;
			end
		end
		s = {raw.sign, 14'd0};
		bexp = 9'(signed'({4'd0, msb}) + 9'(raw.k) + 9'sd7);
		sh = 9'(9'(raw.k) + 9'sd16);
		mant = 25'd0;
		if (raw.special) res = raw.spec_val;
		else if (!nz) res = s;
		else if (bexp >= 9'sd15) res = s | 15'h3C00;
		else if (bexp >= 9'sd1) begin
			if (msb >= 5'd10) mant = raw.n >> (msb - 5'd10);
			else mant = raw.n << (5'd10 - msb);
			res = s | {1'b0, bexp[3:0], mant[9:0]};
		end else begin
			if (sh >= 9'sd0) mant = raw.n << sh[4:0];
			else if (sh <= -9'sd25) mant = 25'd0;
			else mant = raw.n >> 5'(-sh);
			res = s | {5'd0, mant[9:0]};
		end
	end
endmodule

### sv/minifloat15_add_mul_unit.sv
// Top level: three-stage pipelined 15-bit minifloat adder and multiplier.
`timescale 1ns / 1ps
// Takes one transfer per clock while the output is not stalled: operands
// are registered (s1), the front stage forms the exact aligned sum or
// integer product (s2), the pack stage normalizes and truncates (s3). The
// result is registered in s3 after passing s1 and s2; a stall on the output
// freezes all stages together, so throughput is one item per cycle
// whenever the consumer keeps ready high.
module minifloat15_add_mul_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [14:0] operand_a,
	input  logic [14:0] operand_b,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [14:0] result
);
	logic                v_s1, v_s2, v_s3;
	logic                act_s1;
	logic [14:0]         a_s1, b_s1, res_s3, res_c;
	mf15_pkg::mf15_raw_t raw_c, raw_s2;
	logic                adv;

	// whole pipe advances unless the final result is stuck
	assign adv = !v_s3 || out_ready;
	assign in_ready = adv;

	mf15_front u_front (.action(act_s1), .operand_a(a_s1), .operand_b(b_s1), .raw(raw_c));
	mf15_pack  u_pack  (.raw(raw_s2), .res(res_c));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid; v_s2 <= v_s1; v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1 <= action; a_s1 <= operand_a; b_s1 <= operand_b;
			raw_s2 <= raw_c;
			res_s3 <= res_c;
		end
	end

	assign out_valid = v_s3;
	assign result    = res_s3;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result)) else $error("result dropped");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> v_s1) else $error("transfer lost");
	a_move: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && adv |=> v_s3) else $error("stage 2 lost");
endmodule
